@@ rtl/core/rapqt_pkg.sv @@
// shared types and constants of the range-add / point-query segment tree
// no dependencies; used by the top level, rapqt_ctrl and rapqt_datapath by scoped names

package rapqt_pkg;

    // tree geometry
    localparam int LEAVES = 1024;
    localparam int LEVELS = $clog2(LEAVES);
    localparam int NODES  = 2 * LEAVES - 1;
    localparam int IDX_W  = LEVELS + 1;
    localparam int ADDR_W = $clog2(NODES);

    // payload widths fixed by the interface
    localparam int RANGE_W = 11;
    localparam int POS_W   = 10;
    localparam int DATA_W  = 64;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_QUERY,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              capture;   // latch amount, zero the accumulator
        logic              rd;        // read node at addr
        logic              rmw;       // read is for add write-back, not accumulate
        logic              wr_clear;  // write zero at addr
        logic              out_load;  // move accumulator into output register
        logic [ADDR_W-1:0] addr;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;  // output register holds a beat that is not taken this cycle
    } dp_stat_t;

endpackage

@@ rtl/core/range_add_point_query_tree_unit.sv @@
// top level of the range-add / point-query segment tree
// depends on rapqt_pkg, rapqt_ctrl, rapqt_datapath (and rapqt_ram below it)
//
// usage:
//   input channel s_*: one beat is either a range add (s_operation = 0), which puts
//   s_amount on every position in [s_left, s_right), s_right clamped to the leaf
//   count, or a point query (s_operation = 1) for leaf s_position
//   result channel m_*: one beat per query carrying the wrapped 64-bit sum on the
//   path from that leaf to the root; adds produce no beat
// operation:
//   one item at a time: a query reads log2(LEAVES)+1 nodes, leaf to root, and its
//   sum is accumulated as the reads return, then moved into the output register
//   from ST_OUT; a range add visits the levels bottom up, with an extra step per
//   left boundary node and a final check; s_ready is high only in ST_IDLE, after
//   that check or after the result is loaded
// reset:
//   aresetn is synchronous, active low; afterwards the node store is zeroed by a
//   clearing pass over all 2*LEAVES-1 nodes (2047) with s_ready low
// stall:
//   a waiting result sits in the output register while the next item is taken;
//   a later query holds at its end until that beat leaves

module range_add_point_query_tree_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic        [rapqt_pkg::RANGE_W-1:0] s_left,
    input  logic        [rapqt_pkg::RANGE_W-1:0] s_right,
    input  logic signed [rapqt_pkg::DATA_W-1:0]  s_amount,
    input  logic        [rapqt_pkg::POS_W-1:0]   s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rapqt_pkg::DATA_W-1:0]  m_point_value
);

    // command and status between sequencer and datapath
    rapqt_pkg::dp_cmd_t  cmd;
    rapqt_pkg::dp_stat_t stat;

    logic [rapqt_pkg::DATA_W-1:0] point_value;

    // sequencer walks the tree, issuing the node addresses in turn
    rapqt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_left      (s_left),
        .s_right     (s_right),
        .s_position  (s_position),
        .cmd         (cmd),
        .stat        (stat)
    );

    // node store with read-modify-write for adds and accumulate for queries
    rapqt_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_amount      (s_amount),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_value (point_value)
    );

    assign m_point_value = point_value;

endmodule

@@ rtl/core/rapqt_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module rapqt_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/rapqt_datapath.sv @@
// node store, read-modify-write adder, query accumulator and output register
// depends on rapqt_pkg and rapqt_ram

module rapqt_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rapqt_pkg::dp_cmd_t           cmd,
    output rapqt_pkg::dp_stat_t          stat,
    input  logic [rapqt_pkg::DATA_W-1:0] s_amount,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rapqt_pkg::DATA_W-1:0] m_point_value
);

    logic [rapqt_pkg::DATA_W-1:0] amount_reg;
    logic [rapqt_pkg::DATA_W-1:0] acc_reg;
    logic [rapqt_pkg::DATA_W-1:0] out_reg;
    logic                         out_valid_reg;
    logic                         pend_rd_reg;
    logic                         pend_rmw_reg;
    logic [rapqt_pkg::ADDR_W-1:0] pend_addr_reg;

    logic                         mem_we;
    logic [rapqt_pkg::ADDR_W-1:0] mem_waddr;
    logic [rapqt_pkg::DATA_W-1:0] mem_wdata;
    logic [rapqt_pkg::DATA_W-1:0] mem_rdata;

    // write port: clearing pass or add write-back in the cycle after the read
    assign mem_we    = cmd.wr_clear | (pend_rd_reg & pend_rmw_reg);
    assign mem_waddr = cmd.wr_clear ? cmd.addr : pend_addr_reg;
    assign mem_wdata = cmd.wr_clear ? '0 : (mem_rdata + amount_reg);

    rapqt_ram #(
        .WIDTH (rapqt_pkg::DATA_W),
        .DEPTH (rapqt_pkg::NODES)
    ) u_node_ram (
        .clk     (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (cmd.rd),
        .rd_addr (cmd.addr),
        .rd_data (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_rd_reg   <= 1'b0;
            pend_rmw_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_rd_reg  <= cmd.rd;
            pend_rmw_reg <= cmd.rmw;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= cmd.addr;
        if (cmd.capture) begin
            amount_reg <= s_amount;
            acc_reg    <= '0;
        end else if (pend_rd_reg && !pend_rmw_reg) begin
            acc_reg <= acc_reg + mem_rdata;
        end
        if (cmd.out_load) begin
            out_reg <= acc_reg;
        end
    end

    assign stat.out_full = out_valid_reg & ~m_ready;
    assign m_valid       = out_valid_reg;
    assign m_point_value = out_reg;

`ifndef NO_ASSERTIONS
    // a result beat is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(out_valid_reg && !m_ready))
        else $error("output beat overwritten");

    // clearing pass and add write-back never share the write port
    a_wr_port_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_clear |-> !pend_rd_reg)
        else $error("write port conflict");

    // no new item starts while a node read is still returning
    a_capture_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> !pend_rd_reg && !cmd.rd)
        else $error("capture during node access");
`endif

endmodule

@@ rtl/core/rapqt_ctrl.sv @@
// sequencer: clearing pass, level walk for range adds, leaf-to-root walk for queries
// depends on rapqt_pkg

module rapqt_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [rapqt_pkg::RANGE_W-1:0] s_left,
    input  logic [rapqt_pkg::RANGE_W-1:0] s_right,
    input  logic [rapqt_pkg::POS_W-1:0]   s_position,
    output rapqt_pkg::dp_cmd_t            cmd,
    input  rapqt_pkg::dp_stat_t           stat
);

    rapqt_pkg::state_t            state_reg, state_next;
    logic [rapqt_pkg::IDX_W-1:0]  lo_reg, lo_next;
    logic [rapqt_pkg::IDX_W-1:0]  hi_reg, hi_next;
    logic [rapqt_pkg::IDX_W-1:0]  off_reg, off_next;
    logic [rapqt_pkg::ADDR_W-1:0] node_reg, node_next;
    logic [rapqt_pkg::ADDR_W-1:0] clr_reg, clr_next;

    logic [rapqt_pkg::RANGE_W-1:0] right_clamp;

    assign right_clamp = (s_right > rapqt_pkg::RANGE_W'(rapqt_pkg::LEAVES))
                       ? rapqt_pkg::RANGE_W'(rapqt_pkg::LEAVES) : s_right;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rapqt_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        off_reg  <= off_next;
        node_reg <= node_next;
    end

    always_comb begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        off_next   = off_reg;
        node_next  = node_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rapqt_pkg::ST_CLEAR: begin
                cmd.wr_clear = 1'b1;
                cmd.addr     = clr_reg;
                if (clr_reg == rapqt_pkg::ADDR_W'(rapqt_pkg::NODES - 1)) begin
                    state_next = rapqt_pkg::ST_IDLE;
                end else begin
                    clr_next = clr_reg + rapqt_pkg::ADDR_W'(1);
                end
            end
            rapqt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_operation == rapqt_pkg::OP_QUERY) begin
                        node_next  = rapqt_pkg::ADDR_W'(rapqt_pkg::LEAVES - 1)
                                   + rapqt_pkg::ADDR_W'(s_position[rapqt_pkg::LEVELS-1:0]);
                        state_next = rapqt_pkg::ST_QUERY;
                    end else begin
                        hi_next    = rapqt_pkg::IDX_W'(right_clamp);
                        // empty or reversed range walks zero levels
                        lo_next    = (s_left < right_clamp) ? rapqt_pkg::IDX_W'(s_left)
                                                            : rapqt_pkg::IDX_W'(right_clamp);
                        off_next   = rapqt_pkg::IDX_W'(rapqt_pkg::LEAVES - 1);
                        state_next = rapqt_pkg::ST_ADD;
                    end
                end
            end
            rapqt_pkg::ST_ADD: begin
                if (lo_reg >= hi_reg) begin
                    state_next = rapqt_pkg::ST_IDLE;
                end else if (lo_reg[0]) begin
                    // left boundary node, then stay on this level for the right one
                    cmd.rd   = 1'b1;
                    cmd.rmw  = 1'b1;
                    cmd.addr = rapqt_pkg::ADDR_W'(off_reg) + rapqt_pkg::ADDR_W'(lo_reg);
                    lo_next  = lo_reg + rapqt_pkg::IDX_W'(1);
                end else begin
                    if (hi_reg[0]) begin
                        cmd.rd   = 1'b1;
                        cmd.rmw  = 1'b1;
                        cmd.addr = rapqt_pkg::ADDR_W'(off_reg) + rapqt_pkg::ADDR_W'(hi_reg)
                                 - rapqt_pkg::ADDR_W'(1);
                    end
                    lo_next  = lo_reg >> 1;
                    hi_next  = hi_reg >> 1;
                    off_next = off_reg >> 1;
                end
            end
            rapqt_pkg::ST_QUERY: begin
                cmd.rd   = 1'b1;
                cmd.addr = node_reg;
                if (node_reg == '0) begin
                    state_next = rapqt_pkg::ST_DRAIN;
                end else begin
                    node_next = (node_reg - rapqt_pkg::ADDR_W'(1)) >> 1;
                end
            end
            rapqt_pkg::ST_DRAIN: begin
                state_next = rapqt_pkg::ST_OUT;
            end
            rapqt_pkg::ST_OUT: begin
                if (!stat.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = rapqt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rapqt_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // right end never exceeds the width of the current level
    a_hi_in_level: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rapqt_pkg::ST_ADD |-> hi_reg <= off_reg + rapqt_pkg::IDX_W'(1))
        else $error("range end beyond level");

    // every node read stays inside the store
    a_rd_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> cmd.addr <= rapqt_pkg::ADDR_W'(rapqt_pkg::NODES - 1))
        else $error("node read out of range");

    // a query walk ends on the root and then drains
    a_query_ends_root: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rapqt_pkg::ST_QUERY && node_reg == '0 |=>
        state_reg == rapqt_pkg::ST_DRAIN)
        else $error("query walk did not end at root");
`endif

endmodule

@@ dv/tb_range_add_point_query_tree_unit.sv @@
// self-checking testbench for range_add_point_query_tree_unit (range add / point query tree)
// depends on rapqt_pkg and the unit's RTL; keeps its own mirror of the node store to predict sums

module tb_range_add_point_query_tree_unit;

    localparam int LEAVES      = rapqt_pkg::LEAVES;
    localparam int NODES       = rapqt_pkg::NODES;
    localparam int RANGE_W     = rapqt_pkg::RANGE_W;
    localparam int POS_W       = rapqt_pkg::POS_W;
    localparam int DATA_W      = rapqt_pkg::DATA_W;
    // covers the longest add walk and any trailing work
    localparam int SETTLE_CYCLES = 30;
    // idle limit, above the clearing pass after reset and the longest gaps and stalls
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 470;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_operation;
    logic [RANGE_W-1:0]       s_left;
    logic [RANGE_W-1:0]       s_right;
    logic [DATA_W-1:0]        s_amount;
    logic [POS_W-1:0]         s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_point_value;

    // mirror of the node store and the sums still owed by the unit, oldest first
    logic [DATA_W-1:0] mirror_nodes [0:NODES-1];
    logic [DATA_W-1:0] pending_sums [$];

    int  fail_count;
    int  reports_made;
    int  adds_sent;
    int  queries_sent;
    int  sums_checked;
    int  idle_cycles;
    int  sink_hold;
    bit  src_gaps_on;
    bit  sink_stalls_on;

    range_add_point_query_tree_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_left        (s_left),
        .s_right       (s_right),
        .s_amount      (s_amount),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_value (m_point_value)
    );

    // 4 unit clock period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // prediction: the same level-by-level walk the unit does
    // ---------------------------------------------------------------

    // add amt to every leaf in [lo, hi), hi clamped to the leaf count
    function automatic void mirror_range_add(logic [RANGE_W-1:0] lo_in,
                                             logic [RANGE_W-1:0] hi_in,
                                             logic [DATA_W-1:0] amt);
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        lo   = int'(lo_in);
        hi   = int'(hi_in);
        span = LEAVES;
        if (hi > LEAVES) begin
            hi = LEAVES;
        end
        // at most one node per boundary per level; an empty or reversed range
        // never enters the loop
        while (span > 0 && lo < hi) begin
            if ((lo & 1) != 0) begin
                mirror_nodes[span + lo - 1] += amt;
                lo++;
            end
            if ((hi & 1) != 0) begin
                mirror_nodes[span + hi - 2] += amt;
            end
            lo   >>= 1;
            hi   >>= 1;
            span >>= 1;
        end
    endfunction

    // wrapped sum of the nodes on the path from leaf pos up to the root
    function automatic logic [DATA_W-1:0] mirror_point_sum(logic [POS_W-1:0] pos);
        int unsigned       k;
        logic [DATA_W-1:0] acc;
        k   = LEAVES - 1 + pos;
        acc = mirror_nodes[k];
        while (k > 0) begin
            k = (k - 1) >> 1;
            acc += mirror_nodes[k];
        end
        return acc;
    endfunction

    // ---------------------------------------------------------------
    // idle shaping shared by sender and receiver
    // ---------------------------------------------------------------

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // half small signed deltas so sums stay readable, half full 64-bit patterns
    function automatic logic [DATA_W-1:0] rand_amount();
        int delta;
        if ($urandom_range(0, 1) == 0) begin
            delta = $urandom_range(0, 200);
            delta -= 100;
            return longint'(delta);
        end
        return {$urandom(), $urandom()};
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // drive one beat at a falling edge and hold it until it is taken;
    // the mirror is updated at the accepting edge
    task automatic send_beat(input rapqt_pkg::op_t op,
                             input logic [RANGE_W-1:0] lo,
                             input logic [RANGE_W-1:0] hi,
                             input logic [DATA_W-1:0] amt,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 99) < 40) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_left      <= lo;
        s_right     <= hi;
        s_amount    <= amt;
        s_position  <= pos;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (op == rapqt_pkg::OP_QUERY) begin
            pending_sums.push_back(mirror_point_sum(pos));
            queries_sent++;
        end else begin
            mirror_range_add(lo, hi, amt);
            adds_sent++;
        end
    endtask

    // unused position gets random bits
    task automatic send_add(input logic [RANGE_W-1:0] lo,
                            input logic [RANGE_W-1:0] hi,
                            input logic [DATA_W-1:0] amt);
        send_beat(rapqt_pkg::OP_ADD, lo, hi, amt, POS_W'($urandom()));
    endtask

    // unused range and amount get random bits
    task automatic send_query(input logic [POS_W-1:0] pos);
        send_beat(rapqt_pkg::OP_QUERY, RANGE_W'($urandom()), RANGE_W'($urandom()),
                  {$urandom(), $urandom()}, pos);
    endtask

    // drop valid after the last accepted beat and wait for every owed sum
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_sums.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    task automatic report_failure(input string msg);
        fail_count++;
        if (reports_made < 10) begin
            reports_made++;
            $display("ERROR: %s", msg);
        end
    endtask

    // receiver back-pressure, changed at falling edges only
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_ready   <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (sink_stalls_on && $urandom_range(0, 99) < 30) begin
            m_ready   <= 1'b0;
            sink_hold <= idle_len() - 1;
        end else begin
            m_ready   <= 1'b1;
        end
    end

    // every taken result beat against the oldest owed sum
    always @(posedge aclk) begin : check_sums
        logic [DATA_W-1:0] want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_sums.size() == 0) begin
                report_failure($sformatf("result beat with no query waiting: %h",
                                         m_point_value));
            end else begin
                want = pending_sums.pop_front();
                sums_checked++;
                if (m_point_value !== want) begin
                    report_failure($sformatf("point_value expected %h got %h",
                                             want, m_point_value));
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("range_add_point_query_tree_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // store must read as zero after the clearing pass; checks the first, last and middle leaves
    task automatic test_cleared_store();
        send_query('0);
        send_query(POS_W'(LEAVES - 1));
        send_query(POS_W'(LEAVES / 2));
    endtask

    // extreme amounts, clamped, empty, reversed and out-of-range ranges
    task automatic test_boundary_ranges();
        send_add(11'd0, 11'd1024, 64'h7FFF_FFFF_FFFF_FFFF);   // whole tree, max positive
        send_add(11'd0, 11'd1, 64'h8000_0000_0000_0000);      // first leaf, most negative
        send_add(11'd1023, 11'd1024, '1);                     // last leaf, minus one
        send_add(11'd1000, 11'd2047, 64'd5);                  // right end clamped
        send_add(11'd7, 11'd7, 64'd99);                       // empty
        send_add(11'd20, 11'd3, 64'd77);                      // reversed
        send_add(11'd1500, 11'd2000, 64'd33);                 // left past the leaves
        send_add(11'd2047, 11'd2047, 64'd44);                 // all-ones bounds
        send_add(11'd3, 11'd17, 64'h0123_4567_89AB_CDEF);     // odd ends on both sides
        // a query with every unused field at all ones
        send_beat(rapqt_pkg::OP_QUERY, '1, '1, '1, 10'd0);
        send_query(10'd1);
        send_query(10'd3);
        send_query(10'd16);
        send_query(10'd17);
        send_query(10'd999);
        send_query(10'd1000);
        send_query(10'd1023);
        send_query(10'd5);
        send_query(10'b01_0101_0101);
        send_query(10'b10_1010_1010);
    endtask

    // sender holds off until the unit has returned everything it owes
    task automatic test_drain_pause();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        repeat (6) begin
            send_add(RANGE_W'($urandom_range(0, 1023)), RANGE_W'($urandom_range(0, 1024)),
                     rand_amount());
            send_query(POS_W'($urandom()));
        end
        drain_results();
        repeat (3) send_query(POS_W'($urandom()));
    endtask

    // mixed traffic: a quiet stretch, a receiver-only stall stretch, then both sides idling
    task automatic test_random_traffic();
        int                 n;
        int                 pick;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 0) begin
                src_gaps_on    = 1'b0;
                sink_stalls_on = 1'b0;
            end else if (n == 100) begin
                sink_stalls_on = 1'b1;
            end else if (n == 180) begin
                src_gaps_on    = 1'b1;
            end
            if ($urandom_range(0, 99) < 45) begin
                send_query(POS_W'($urandom()));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    // short range, the common case
                    lo = RANGE_W'($urandom_range(0, 1023));
                    hi = lo + RANGE_W'($urandom_range(0, 16));
                end else if (pick < 75) begin
                    // wide range inside the tree
                    lo = RANGE_W'($urandom_range(0, 512));
                    hi = RANGE_W'($urandom_range(lo, 1024));
                end else if (pick < 90) begin
                    // raw bounds, often clamped, empty or reversed
                    lo = RANGE_W'($urandom());
                    hi = RANGE_W'($urandom());
                end else begin
                    lo = '0;
                    hi = RANGE_W'($urandom_range(1000, 2047));
                end
                send_add(lo, hi, rand_amount());
            end
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = rapqt_pkg::OP_ADD;
        s_left         = '0;
        s_right        = '0;
        s_amount       = '0;
        s_position     = '0;
        m_ready        = 1'b0;
        fail_count     = 0;
        reports_made   = 0;
        adds_sent      = 0;
        queries_sent   = 0;
        sums_checked   = 0;
        idle_cycles    = 0;
        sink_hold      = 0;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            mirror_nodes[i] = '0;
        end

        // single reset, released at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_cleared_store();
        test_boundary_ranges();
        test_drain_pause();
        test_random_traffic();

        // let the last sums come back, then give any trailing add walk time to end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (pending_sums.size() != 0) begin
            report_failure($sformatf("%0d query results never arrived",
                                     pending_sums.size()));
        end

        $display("covered %0d range adds and %0d point queries, %0d sums compared",
                 adds_sent, queries_sent, sums_checked);
        $display("stimulus included clamped, empty and reversed ranges under random stalls");
        if (fail_count == 0) begin
            $display("range_add_point_query_tree_unit verification clean");
        end else begin
            $display("%0d failures", fail_count);
            $display("range_add_point_query_tree_unit verification failed");
        end
        $finish;
    end

endmodule
